// ===== rtl/tridiagonal_thomas_solver_core_defines.svh =====
// Assertion macros used by the checker file of the tridiagonal solver.
// No dependencies; included by bare file name.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_CORE_DEFINES_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttsc assertion failed");

// Next-cycle implication, disabled during reset.
`define TTSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttsc assertion failed");

`endif

// ===== rtl/ttsc_pkg.sv =====
// Shared types and constants of the tridiagonal solver.
// No dependencies.
`default_nettype none
package ttsc_pkg;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 64;
    localparam int DIV_STEPS = 64;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_ZERO = 2'd1;
    localparam t_status ST_SAT  = 2'd2;
    localparam t_status ST_DROP = 2'd3;

    typedef struct packed {
        logic zero;
        logic sat;
    } t_div_flags;

    typedef struct packed {
        logic [WORD_W-1:0] diag;
        logic [WORD_W-1:0] sup;
        logic [WORD_W-1:0] rhs;
    } t_row;

    function automatic t_status st_max(t_status a, t_status b);
        return (a > b) ? a : b;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/ttsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ttsc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ttsc_div.sv =====
// Radix-2 signed divider, 64-bit dividend by 32-bit divisor, truncating,
// with clamp to 32 bits and zero-divisor flag. Uses ttsc_pkg.
`default_nettype none
module ttsc_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [63:0]  i_num,
    input  wire logic signed [31:0]  i_den,
    output logic                     o_done,
    output logic signed [31:0]       o_quot,
    output ttsc_pkg::t_div_flags     o_flags
);
    import ttsc_pkg::*;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_d;
    logic        r_neg;
    logic        r_zero;

    logic [63:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    assign num_mag = i_num[63] ? (~i_num + 64'd1) : i_num;
    assign den_mag = i_den[31] ? (~i_den + 32'd1) : i_den;
    assign trial   = {r_rem, r_q[63]};
    assign diff    = trial - {1'b0, r_d};
    assign fits    = (trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= num_mag;
                r_d    <= den_mag;
                r_neg  <= i_num[63] ^ i_den[31];
                r_zero <= (i_den == '0);
            end else if (r_busy) begin
                if (r_cnt != 7'(DIV_STEPS)) begin
                    r_rem <= fits ? diff[31:0] : trial[31:0];
                    r_q   <= {r_q[62:0], fits};
                    r_cnt <= r_cnt + 7'd1;
                end else begin
                    // finish: sign, clamp
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_flags.zero <= r_zero;
                    if (r_zero) begin
                        o_quot      <= '0;
                        o_flags.sat <= 1'b0;
                    end else if (r_neg) begin
                        o_flags.sat <= (r_q > 64'h0000_0000_8000_0000);
                        o_quot <= (r_q > 64'h0000_0000_8000_0000) ? 32'sh8000_0000
                                                                 : (~r_q[31:0] + 32'd1);
                    end else begin
                        o_flags.sat <= (r_q > 64'h0000_0000_7FFF_FFFF);
                        o_quot <= (r_q > 64'h0000_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                                 : r_q[31:0];
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/tridiagonal_thomas_solver_core.sv =====
// Tridiagonal solver top level: sequencer, shared multiplier, row memory, divider.
// Depends on ttsc_pkg, ttsc_ram, ttsc_div.
//
// Usage:
//  Input channel (i_valid / o_stall): one word per matrix row, row zero
//  first; i_row_last marks the final row. Output channel (o_valid /
//  i_stall): one word per solution entry, highest index first, o_run_last
//  on index zero, o_status_code the worst event of the run so far.
//  Forward elimination: row zero is written on acceptance; every later row
//  takes a memory read of the previous row, two multiply + divide passes
//  through one radix-2 divider and a write-back; the divider dominates the
//  time per row.
//  Back pass: per entry a read, a multiply and one divide, plus the time
//  the receiver stalls. A finished entry sits in the output register
//  while the next one is computed; the sequencer waits only when that
//  register is still full.
//  A row beyond MAX_ROWS is dropped with status 3.
//  o_stall is high whenever a row or the back pass is in progress.
//  Reset (synchronous, active low) clears the row count, status and
//  output valid; the row memory needs no clearing since each run writes
//  every entry before reading it.
`default_nettype none
module tridiagonal_thomas_solver_core #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_sub_coeff,
    input  wire logic signed [31:0] i_diag_coeff,
    input  wire logic signed [31:0] i_super_coeff,
    input  wire logic signed [31:0] i_rhs_value,
    input  wire logic               i_row_last,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_solution_value,
    output logic [5:0]              o_solution_index,
    output logic                    o_run_last,
    output logic [1:0]              o_status_code
);
    import ttsc_pkg::*;

    localparam int IW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_FRD  = 11'b000_0000_0010,   // read previous row
        S_FM1  = 11'b000_0000_0100,   // sub * super[i-1]
        S_FD1  = 11'b000_0000_1000,
        S_FM2  = 11'b000_0001_0000,   // sub * rhs[i-1]
        S_FD2  = 11'b000_0010_0000,
        S_FWR  = 11'b000_0100_0000,   // update and write row i
        S_BRD  = 11'b000_1000_0000,   // back pass read row k
        S_BMUL = 11'b001_0000_0000,   // super[k] * x[k+1]
        S_BDIV = 11'b010_0000_0000,
        S_BOUT = 11'b100_0000_0000    // hand x[k] to output register
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_k;
    t_status            r_sticky, n_sticky;
    logic               r_first;
    logic               r_go;

    logic signed [31:0] r_sub, r_diag, r_sup, r_rhs;
    logic               r_last;
    logic signed [31:0] r_pd, r_pr, r_bd, r_br;
    logic signed [31:0] r_q1, r_q2, r_next;
    logic signed [63:0] r_prod;

    // memory
    logic               mem_we;
    logic [IW-1:0]      mem_waddr, mem_raddr;
    t_row               mem_wdata, mem_rdata;

    // divider
    logic               div_done;
    logic signed [31:0] div_quot;
    t_div_flags         div_flags;
    logic signed [63:0] div_num;
    logic signed [31:0] div_den;

    logic               in_acc, out_free;
    logic signed [31:0] mul_a, mul_b;
    logic signed [32:0] dd, dr;
    logic signed [31:0] nd, nr;
    logic               nd_sat, nr_sat;
    logic signed [63:0] scaled, back_num;

    assign in_acc   = i_valid && !o_stall && (r_state == S_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    ttsc_ram #(.WIDTH($bits(t_row)), .DEPTH(MAX_ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ttsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_flags (div_flags)
    );

    // diag - q1, rhs - q2 with clamp
    assign dd     = {r_diag[31], r_diag} - {r_q1[31], r_q1};
    assign dr     = {r_rhs[31], r_rhs} - {r_q2[31], r_q2};
    assign nd_sat = dd[32] != dd[31];
    assign nr_sat = dr[32] != dr[31];
    assign nd     = nd_sat ? (dd[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dd[31:0];
    assign nr     = nr_sat ? (dr[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dr[31:0];

    // back pass numerator: rhs * 2^FRAC_BITS - super * x[k+1]
    assign scaled   = {{32{r_br[31]}}, r_br} <<< FRAC_BITS;
    assign back_num = r_first ? scaled : (scaled - r_prod);
    assign div_num  = (r_state == S_BDIV) ? back_num : r_prod;
    assign div_den  = (r_state == S_BDIV) ? r_bd : r_pd;

    // one shared multiplier
    always_comb begin
        mul_a = r_sub;
        mul_b = r_pr;
        if (r_state == S_FM1) begin
            mul_b = mem_rdata.sup;
        end else if (r_state == S_BMUL) begin
            mul_a = mem_rdata.sup;
            mul_b = r_next;
        end
    end

    always_comb begin
        mem_we    = (in_acc && r_count == '0) || (r_state == S_FWR);
        mem_waddr = (r_state == S_FWR) ? r_count[IW-1:0] : '0;
        mem_wdata = (r_state == S_FWR) ? t_row'({nd, r_sup, nr})
                                       : t_row'({i_diag_coeff, i_super_coeff, i_rhs_value});
        mem_raddr = (r_state == S_FRD) ? IW'(r_count[IW-1:0] - 1'b1) : r_k;
    end

    always_comb begin
        n_state  = r_state;
        n_sticky = r_sticky;
        if (div_done) begin
            if (div_flags.zero) n_sticky = st_max(n_sticky, ST_ZERO);
            if (div_flags.sat)  n_sticky = st_max(n_sticky, ST_SAT);
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_count == CW'(MAX_ROWS)) begin
                        n_sticky = st_max(n_sticky, ST_DROP);
                        n_state  = i_row_last ? S_BRD : S_IDLE;
                    end else if (r_count == '0) begin
                        n_state  = i_row_last ? S_BRD : S_IDLE;
                    end else begin
                        n_state  = S_FRD;
                    end
                end
            end
            S_FRD:  n_state = S_FM1;
            S_FM1:  n_state = S_FD1;
            S_FD1:  if (div_done) n_state = S_FM2;
            S_FM2:  n_state = S_FD2;
            S_FD2:  if (div_done) n_state = S_FWR;
            S_FWR: begin
                if (nd_sat || nr_sat) n_sticky = st_max(n_sticky, ST_SAT);
                n_state = r_last ? S_BRD : S_IDLE;
            end
            S_BRD:  n_state = S_BMUL;
            S_BMUL: n_state = S_BDIV;
            S_BDIV: if (div_done) n_state = S_BOUT;
            S_BOUT: begin
                if (out_free) begin
                    n_state = (r_k == '0) ? S_IDLE : S_BRD;
                    // run over: status starts fresh
                    if (r_k == '0) n_sticky = ST_OK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sticky <= ST_OK;
            r_go     <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sticky <= n_sticky;
            r_go     <= (r_state == S_FM1) || (r_state == S_FM2) || (r_state == S_BMUL);

            if ((r_state == S_BOUT) && out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_first <= 1'b1;
                        if (r_count == CW'(MAX_ROWS)) begin
                            r_k <= IW'(MAX_ROWS - 1);
                        end else if (r_count == '0) begin
                            r_count <= CW'(1);
                            r_k     <= '0;
                        end
                    end
                end
                S_FWR: begin
                    r_count <= r_count + 1'b1;
                    r_k     <= r_count[IW-1:0];
                end
                S_BOUT: begin
                    if (out_free) begin
                        r_first <= 1'b0;
                        if (r_k == '0) begin
                            r_count <= '0;
                        end else begin
                            r_k <= r_k - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sub  <= i_sub_coeff;
            r_diag <= i_diag_coeff;
            r_sup  <= i_super_coeff;
            r_rhs  <= i_rhs_value;
            r_last <= i_row_last;
        end
        if (r_state == S_FM1) begin
            r_pd <= mem_rdata.diag;
            r_pr <= mem_rdata.rhs;
        end
        if (r_state == S_BMUL) begin
            r_bd <= mem_rdata.diag;
            r_br <= mem_rdata.rhs;
        end
        if ((r_state == S_FM1) || (r_state == S_FM2) || (r_state == S_BMUL)) begin
            r_prod <= mul_a * mul_b;
        end
        if (div_done) begin
            if (r_state == S_FD1) r_q1 <= div_quot;
            if (r_state == S_FD2) r_q2 <= div_quot;
            if (r_state == S_BDIV) r_next <= div_quot;
        end
        if ((r_state == S_BOUT) && out_free) begin
            o_solution_value <= r_next;
            o_solution_index <= 6'(r_k);
            o_run_last       <= (r_k == '0);
            o_status_code    <= r_sticky;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ttsc_checker.sv =====
// Port-level checks of the tridiagonal solver, bound to the top level.
// Depends on tridiagonal_thomas_solver_core_defines.svh.
`default_nettype none
`include "tridiagonal_thomas_solver_core_defines.svh"
module ttsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_solution_value,
    input wire logic [5:0]  o_solution_index,
    input wire logic        o_run_last
);
    // run end mark sits exactly on index zero
    `TTSC_ASSERT_NOW(a_last_idx, i_clk, i_rst_n, o_valid, o_run_last == (o_solution_index == 6'd0))
    // mid-run entries only while the back pass holds off new rows
    `TTSC_ASSERT_NOW(a_run_busy, i_clk, i_rst_n, o_valid && !o_run_last, o_stall)
    // stalled word holds
    `TTSC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_solution_value))
endmodule

bind tridiagonal_thomas_solver_core ttsc_checker u_ttsc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_solution_value (o_solution_value),
    .o_solution_index (o_solution_index),
    .o_run_last       (o_run_last)
);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking bench for tridiagonal_thomas_solver_core: rows go in, solution words come out.
// Depends on ttsc_pkg and the solver RTL; has its own fixed-point elimination predictor.
`default_nettype none
module tb;
    import ttsc_pkg::*;

    localparam int ROWS_CAP = 64;
    localparam int SCALE_SH = 16;
    localparam longint W_MAX = 64'sd2147483647;
    localparam longint W_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] value;
        logic [5:0]         index;
        logic               run_last;
        t_status            status;
    } t_solution_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_sub_coeff = '0;
    logic signed [31:0] i_diag_coeff = '0;
    logic signed [31:0] i_super_coeff = '0;
    logic signed [31:0] i_rhs_value = '0;
    logic               i_row_last = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_solution_value;
    logic [5:0]         o_solution_index;
    logic               o_run_last;
    logic [1:0]         o_status_code;

    tridiagonal_thomas_solver_core uut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] elim_diag [ROWS_CAP];
    logic signed [31:0] elim_super[ROWS_CAP];
    logic signed [31:0] elim_rhs  [ROWS_CAP];
    int                 rows_held;
    t_status            run_status;
    t_solution_word     pending_solutions[$];

    int  mismatches = 0;
    int  rows_sent = 0;
    bit  gaps_on = 1'b1;
    int  hold_off = 0;

    function automatic void raise_status(t_status code);
        if (code > run_status) run_status = code;
    endfunction

    function automatic longint clamp_word(longint v);
        if (v > W_MAX) begin raise_status(ST_SAT); return W_MAX; end
        if (v < W_MIN) begin raise_status(ST_SAT); return W_MIN; end
        return v;
    endfunction

    function automatic longint fx_quot(longint num, longint den);
        if (den == 0) begin raise_status(ST_ZERO); return 0; end
        return clamp_word(num / den);
    endfunction

    // forward elimination for one row; back pass on the last one
    function automatic void eliminate_row(logic signed [31:0] sub, logic signed [31:0] dg,
                                          logic signed [31:0] sp, logic signed [31:0] rh,
                                          logic last);
        longint pivot, q1, q2, num, x, nxt;
        int n;
        t_solution_word w;
        nxt = 0;
        if (rows_held < ROWS_CAP) begin
            if (rows_held == 0) begin
                elim_diag[0] = dg;
                elim_rhs[0]  = rh;
            end else begin
                pivot = elim_diag[rows_held-1];
                q1 = fx_quot(longint'(sub) * longint'(elim_super[rows_held-1]), pivot);
                q2 = fx_quot(longint'(sub) * longint'(elim_rhs[rows_held-1]), pivot);
                elim_diag[rows_held] = 32'(clamp_word(longint'(dg) - q1));
                elim_rhs[rows_held]  = 32'(clamp_word(longint'(rh) - q2));
            end
            elim_super[rows_held] = sp;
            rows_held++;
        end else begin
            raise_status(ST_DROP);
        end
        if (!last) return;
        n = rows_held;
        for (int k = n - 1; k >= 0; k--) begin
            num = longint'(elim_rhs[k]) <<< SCALE_SH;
            if (k != n - 1) num -= longint'(elim_super[k]) * nxt;
            x = fx_quot(num, longint'(elim_diag[k]));
            nxt = x;
            w.value = 32'(x);
            w.index = 6'(k);
            w.run_last = (k == 0);
            w.status = run_status;
            pending_solutions.push_back(w);
        end
        rows_held = 0;
        run_status = ST_OK;
    endfunction

    // one row word: drive at falling edge, hold until accepted
    task automatic send_row(logic signed [31:0] sub, logic signed [31:0] dg,
                            logic signed [31:0] sp, logic signed [31:0] rh, logic last);
        int gap;
        i_sub_coeff = sub; i_diag_coeff = dg; i_super_coeff = sp;
        i_rhs_value = rh; i_row_last = last; i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        eliminate_row(sub, dg, sp, rh, last);
        rows_sent++;
        @(negedge i_clk);
        gap = 0;
        if (gaps_on && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain;
        i_valid = 1'b0;
        while (pending_solutions.size() != 0) @(negedge i_clk);
    endtask

    // random well-conditioned row, or raw noise
    task automatic send_system(int n, bit noisy);
        logic signed [31:0] a, b, c, r;
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 3) == 0) begin
                a = $urandom; b = $urandom; c = $urandom; r = $urandom;
            end else begin
                a = $signed($urandom_range(0, 131071)) - 65536;
                c = $signed($urandom_range(0, 131071)) - 65536;
                b = $signed($urandom_range(3 << 16, 10 << 16));
                if ($urandom_range(0, 1)) b = -b;
                r = $signed($urandom_range(0, 200 << 16)) - (100 << 16);
            end
            send_row(a, b, c, r, i == n - 1);
        end
    endtask

    task automatic test_directed;
        send_row(0, 2 << 16, 0, 6 << 16, 1);                    // single row
        send_row(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
        send_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1);
        send_row(0, 0, 0, 5 << 16, 1);                          // zero diagonal alone
        send_row(0, 0, 1 << 16, 1 << 16, 0);                    // zero pivot into row one
        send_row(1 << 16, 2 << 16, 0, 1 << 16, 1);
        send_row(0, 1, 0, 32'sh7fffffff, 1);                    // quotient saturates
        send_row(0, 4 << 16, 1 << 16, 1 << 16, 0);              // plain three rows
        send_row(1 << 16, 4 << 16, 1 << 16, 2 << 16, 0);
        send_row(1 << 16, 4 << 16, 32'sh12345678, 3 << 16, 1);
        send_row(32'sh80000000, 1, 32'sh7fffffff, 32'sh80000000, 0);
        send_row(32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff, 1);
        drain();
    endtask

    task automatic test_capacity;
        send_system(ROWS_CAP + 2, 1'b0);                        // two rows dropped
        drain();
    endtask

    task automatic test_backpressure;
        hold_off = 600;
        gaps_on = 1'b0;
        send_system(4, 1'b0);
        send_system(3, 1'b0);
        gaps_on = 1'b1;
        drain();
    endtask

    task automatic test_random;
        int target;
        target = rows_sent + 15;
        while (rows_sent < target) begin
            if ($urandom_range(0, 5) == 0) gaps_on = ~gaps_on;
            send_system(($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                    : $urandom_range(1, 6),
                        $urandom_range(0, 4) == 0);
        end
        gaps_on = 1'b1;
        drain();
    endtask

    // receiver: random stall bursts, plus a counted long hold-off on request
    always @(negedge i_clk) begin
        static int burst = 0;
        if (hold_off > 0) begin
            i_stall = 1'b1;
            hold_off--;
        end else if (burst > 0) begin
            i_stall = 1'b1;
            burst--;
        end else begin
            i_stall = 1'b0;
            if ($urandom_range(0, 3) == 0)
                burst = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 100)
                                                     : $urandom_range(1, 3);
        end
    end

    // compare each accepted solution word with the oldest prediction
    always @(posedge i_clk) begin
        t_solution_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_solutions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %h index %0d", o_solution_value,
                             o_solution_index);
            end else begin
                want = pending_solutions.pop_front();
                if (o_solution_value !== want.value || o_solution_index !== want.index ||
                    o_run_last !== want.run_last || o_status_code !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%b/%0d got %h/%0d/%b/%0d",
                                 want.value, want.index, want.run_last, want.status,
                                 o_solution_value, o_solution_index, o_run_last,
                                 o_status_code);
                end
            end
        end
    end

    initial begin
        rows_held = 0;
        run_status = ST_OK;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_capacity();
        test_backpressure();
        test_random();
        repeat (300) @(negedge i_clk);
        if (mismatches == 0 && pending_solutions.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
